[hdl/ttp_pkg.sv]
// ----------------------------------------------------------------------------
// ttp_pkg: shared types and helpers for the trapezoidal trajectory planner
// Operation codes, request and response records of the shared arithmetic
// unit, and Q16.16 saturation helpers.
// ----------------------------------------------------------------------------
package ttp_pkg;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Quotient and root iteration counts
    localparam int QDIV_STEPS = 48;
    localparam int STOP_STEPS = 64;
    localparam int SQRT_STEPS = 24;

    typedef enum logic [2:0] {
        ALU_MUL  = 3'd0,   // (a*b)/2^16
        ALU_MULH = 3'd1,   // (a*b)/2^17
        ALU_QDIV = 3'd2,   // (a*2^16)/b
        ALU_STOP = 3'd3,   // (a*a)/(2*b), integer
        ALU_SQRT = 3'd4    // floor(sqrt(a*2^16))
    } t_alu_op;

    typedef struct packed {
        logic               start;
        t_alu_op            op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] res;
    } t_alu_rsp;

    // Sign-extend to the 34-bit working width
    function automatic logic signed [33:0] f_sx34(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    // Clamp a 34-bit value to signed 32 bits
    function automatic logic signed [31:0] f_sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = Q_MIN;
        end else begin
            r = Q_MAX;
        end
        return r;
    endfunction

endpackage

[hdl/ttp_alu.sv]
// ----------------------------------------------------------------------------
// ttp_alu: shared multi-cycle arithmetic unit
// One 32x32 multiplier, a restoring divider (one quotient bit per cycle) and
// a digit-by-digit square root (one root bit per cycle), all saturating.
// ----------------------------------------------------------------------------
module ttp_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttp_pkg::t_alu_req i_req,
    output ttp_pkg::t_alu_rsp o_rsp
);

    typedef enum logic [4:0] {
        AS_IDLE = 5'b00001,
        AS_MUL  = 5'b00010,
        AS_DIV  = 5'b00100,
        AS_DFIN = 5'b01000,
        AS_SQRT = 5'b10000
    } t_alu_state;

    t_alu_state         r_state;
    ttp_pkg::t_alu_op   r_op;
    logic signed [63:0] r_prod;
    logic [63:0]        r_quo;
    logic [32:0]        r_rem;
    logic [32:0]        r_dvs;
    logic               r_neg;
    logic [5:0]         r_cnt;
    logic [23:0]        r_root;
    logic [25:0]        r_srem;
    logic [47:0]        r_sn;
    logic signed [31:0] r_res;
    logic               r_done;

    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;
    logic signed [63:0] adj;
    logic signed [63:0] shv;
    logic signed [31:0] mul_res;
    logic [33:0]        div_rs;
    logic [33:0]        div_diff;
    logic               div_ge;
    logic [63:0]        quo_neg;
    logic [27:0]        sq_rem2;
    logic [27:0]        sq_trial;
    logic               sq_ge;

    // Multiplier (a*b, or a*a for the stop distance) and operand magnitudes
    always_comb begin
        mul_b = (i_req.op == ttp_pkg::ALU_STOP) ? i_req.a : i_req.b;
        mul_p = i_req.a * mul_b;
        mag_a = i_req.a[31] ? (32'd0 - i_req.a) : i_req.a;
        mag_b = i_req.b[31] ? (32'd0 - i_req.b) : i_req.b;
    end

    // Scale the product with truncation toward zero, then clamp
    always_comb begin
        if (r_prod[63]) begin
            adj = r_prod + ((r_op == ttp_pkg::ALU_MULH) ? 64'sd131071 : 64'sd65535);
        end else begin
            adj = r_prod;
        end
        shv = (r_op == ttp_pkg::ALU_MULH) ? (adj >>> 17) : (adj >>> 16);
        if (shv[63:31] == '0 || shv[63:31] == '1) begin
            mul_res = shv[31:0];
        end else if (shv[63]) begin
            mul_res = ttp_pkg::Q_MIN;
        end else begin
            mul_res = ttp_pkg::Q_MAX;
        end
    end

    // One divider step and one root step
    always_comb begin
        div_rs   = {r_rem, r_quo[63]};
        div_diff = div_rs - {1'b0, r_dvs};
        div_ge   = (div_rs >= {1'b0, r_dvs});
        quo_neg  = 64'd0 - r_quo;
        sq_rem2  = {r_srem, r_sn[47:46]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_ge    = (sq_rem2 >= sq_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AS_IDLE;
            r_done  <= 1'b0;
            r_op    <= ttp_pkg::ALU_MUL;
            r_prod  <= '0;
            r_quo   <= '0;
            r_rem   <= '0;
            r_dvs   <= '0;
            r_neg   <= 1'b0;
            r_cnt   <= '0;
            r_root  <= '0;
            r_srem  <= '0;
            r_sn    <= '0;
            r_res   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                AS_IDLE: begin
                    if (i_req.start) begin
                        r_op <= i_req.op;
                        unique case (i_req.op)
                            ttp_pkg::ALU_MUL, ttp_pkg::ALU_MULH: begin
                                r_prod  <= mul_p;
                                r_state <= AS_MUL;
                            end
                            ttp_pkg::ALU_STOP: begin
                                r_prod  <= mul_p;
                                r_dvs   <= {i_req.b, 1'b0};
                                r_state <= AS_MUL;
                            end
                            ttp_pkg::ALU_QDIV: begin
                                if (i_req.b == 32'sd0) begin
                                    // Divide by zero: clamp by numerator sign
                                    if (i_req.a[31]) begin
                                        r_res <= ttp_pkg::Q_MIN;
                                    end else if (i_req.a != 32'sd0) begin
                                        r_res <= ttp_pkg::Q_MAX;
                                    end else begin
                                        r_res <= '0;
                                    end
                                    r_done <= 1'b1;
                                end else begin
                                    // Skip the 16 leading zero bits of |a|*2^16
                                    r_quo   <= {mag_a, 32'd0};
                                    r_rem   <= '0;
                                    r_dvs   <= {1'b0, mag_b};
                                    r_neg   <= i_req.a[31] ^ i_req.b[31];
                                    r_cnt   <= 6'(ttp_pkg::QDIV_STEPS - 1);
                                    r_state <= AS_DIV;
                                end
                            end
                            ttp_pkg::ALU_SQRT: begin
                                if (i_req.a[31] || i_req.a == 32'sd0) begin
                                    r_res  <= '0;
                                    r_done <= 1'b1;
                                end else begin
                                    r_sn    <= {1'b0, i_req.a[30:0], 16'd0};
                                    r_root  <= '0;
                                    r_srem  <= '0;
                                    r_cnt   <= 6'(ttp_pkg::SQRT_STEPS - 1);
                                    r_state <= AS_SQRT;
                                end
                            end
                            default: begin
                                r_res  <= '0;
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                AS_MUL: begin
                    if (r_op == ttp_pkg::ALU_STOP) begin
                        if (r_dvs == '0) begin
                            r_res   <= (r_prod != 64'sd0) ? ttp_pkg::Q_MAX : 32'sd0;
                            r_done  <= 1'b1;
                            r_state <= AS_IDLE;
                        end else begin
                            r_quo   <= r_prod;
                            r_rem   <= '0;
                            r_neg   <= 1'b0;
                            r_cnt   <= 6'(ttp_pkg::STOP_STEPS - 1);
                            r_state <= AS_DIV;
                        end
                    end else begin
                        r_res   <= mul_res;
                        r_done  <= 1'b1;
                        r_state <= AS_IDLE;
                    end
                end
                AS_DIV: begin
                    // Shift in one dividend bit, subtract when it fits
                    r_rem <= div_ge ? div_diff[32:0] : div_rs[32:0];
                    r_quo <= {r_quo[62:0], div_ge};
                    if (r_cnt == '0) begin
                        r_state <= AS_DFIN;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                AS_DFIN: begin
                    // Apply sign and clamp
                    if (!r_neg) begin
                        r_res <= (r_quo > 64'h7FFF_FFFF) ? ttp_pkg::Q_MAX : r_quo[31:0];
                    end else begin
                        r_res <= (r_quo > 64'h8000_0000) ? ttp_pkg::Q_MIN : quo_neg[31:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= AS_IDLE;
                end
                AS_SQRT: begin
                    // Bring down two radicand bits, try the next root bit
                    r_srem <= sq_ge ? 26'(sq_rem2 - sq_trial) : sq_rem2[25:0];
                    r_root <= {r_root[22:0], sq_ge};
                    r_sn   <= {r_sn[45:0], 2'b00};
                    if (r_cnt == '0) begin
                        r_res   <= {8'd0, r_root[22:0], sq_ge};
                        r_done  <= 1'b1;
                        r_state <= AS_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                default: begin
                    r_state <= AS_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

[hdl/trapezoidal_trajectory_planner_unit.sv]
// ----------------------------------------------------------------------------
// trapezoidal_trajectory_planner_unit: one-axis trapezoidal profile planner
// Plans a move (rates and phase times) and evaluates position, velocity and
// acceleration at a time, in signed Q16.16, through one shared ALU.
//
//   channel  direction  handshake               payload
//   in       sink       i_in_valid/o_in_stall   operation, positions, velocity, time
//   out      source     o_out_valid/i_out_stall position, velocity, accel, done, time
//   cfg      sink       i_cfg_valid/o_cfg_ready register index, 31-bit data
//
// Plan: a stop-distance divide, three to five quotient passes, a root pass in
// the triangle case and the multiplier passes of the shared ALU.
// Evaluate: no ALU pass in the pre-start and finished phases, one multiplier
// pass in coast, three in decelerate and four in accelerate.
// Reset restores the limits to 1.0 and clears the stored plan.
// A stalled result is held in the output register; the next item is taken
// once the result of the previous one is in that register.
// ----------------------------------------------------------------------------
module trapezoidal_trajectory_planner_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic signed [31:0] i_target_position,
    input  logic signed [31:0] i_start_position,
    input  logic signed [31:0] i_start_velocity,
    input  logic signed [31:0] i_eval_time,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_position,
    output logic signed [31:0] o_velocity,
    output logic signed [31:0] o_acceleration,
    output logic               o_done_res,
    output logic signed [31:0] o_move_time,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data
);

    localparam logic       OP_PLAN     = 1'b0;
    localparam logic [1:0] CFG_MAX_VEL = 2'd0;
    localparam logic [1:0] CFG_MAX_ACC = 2'd1;
    localparam logic [1:0] CFG_MAX_DEC = 2'd2;
    localparam logic [30:0] LIMIT_RST  = 31'd65536;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    typedef enum logic [4:0] {
        P_STOP, P_TA, P_TD, P_DXM1, P_DXM2, P_VV, P_T2, P_ARDR, P_T4, P_NUM,
        P_SQRT, P_TA2, P_TD2, P_TV, P_AEP1, P_AEP2, P_AEP3,
        E_A1, E_A2, E_A3, E_A4, E_C1, E_D1, E_D2, E_D3
    } t_step;

    t_state             r_state;
    t_step              r_step;
    logic [30:0]        r_max_vel;
    logic [30:0]        r_max_acc;
    logic [30:0]        r_max_dec;

    // stored plan
    logic signed [31:0] r_accel_rate;
    logic signed [31:0] r_decel_rate;
    logic signed [31:0] r_cruise_vel;
    logic signed [31:0] r_accel_dur;
    logic signed [31:0] r_coast_dur;
    logic signed [31:0] r_total_dur;
    logic signed [31:0] r_origin_pos;
    logic signed [31:0] r_goal_pos;
    logic signed [31:0] r_origin_vel;
    logic signed [31:0] r_accel_end_pos;

    // working values
    logic signed [31:0] r_dx;
    logic signed [31:0] r_dxmin;
    logic signed [31:0] r_td;
    logic signed [31:0] r_tmp1;
    logic signed [31:0] r_tmp2;
    logic signed [31:0] r_t;
    logic               r_neg;
    logic signed [31:0] r_res_pos;
    logic signed [31:0] r_res_vel;
    logic signed [31:0] r_res_acc;
    logic               r_res_done;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_out_pos;
    logic signed [31:0] r_out_vel;
    logic signed [31:0] r_out_acc;
    logic               r_out_done;
    logic signed [31:0] r_out_mt;

    ttp_pkg::t_alu_req  alu_req;
    ttp_pkg::t_alu_rsp  alu_rsp;

    logic               in_xfer;
    logic signed [31:0] res;
    logic signed [31:0] w_max_acc;
    logic signed [31:0] w_max_dec;
    logic signed [31:0] w_max_vel;
    logic signed [33:0] w_dxstop;
    logic               w_neg;
    logic signed [31:0] w_ar0;
    logic signed [31:0] w_dr;
    logic signed [31:0] w_vr;
    logic               w_flip;
    logic signed [31:0] w_dxmin;
    logic               w_tri;
    logic signed [31:0] w_num;
    logic signed [31:0] w_total;
    logic signed [31:0] w_tdv;
    logic signed [33:0] w_coast_end;

    assign in_xfer     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign res         = alu_rsp.res;

    // Direction, signed rates and phase-end helpers
    always_comb begin
        w_max_acc   = {1'b0, r_max_acc};
        w_max_dec   = {1'b0, r_max_dec};
        w_max_vel   = {1'b0, r_max_vel};
        w_dxstop    = r_origin_vel[31] ? (34'sd0 - ttp_pkg::f_sx34(res))
                                       : ttp_pkg::f_sx34(res);
        w_neg       = (ttp_pkg::f_sx34(r_dx) - w_dxstop) < 34'sd0;
        w_ar0       = w_neg ? (32'sd0 - w_max_acc) : w_max_acc;
        w_dr        = w_neg ? w_max_dec : (32'sd0 - w_max_dec);
        w_vr        = w_neg ? (32'sd0 - w_max_vel) : w_max_vel;
        w_flip      = w_neg ? (r_origin_vel < w_vr) : (r_origin_vel > w_vr);
        w_dxmin     = ttp_pkg::f_sat34(ttp_pkg::f_sx34(r_tmp1) + ttp_pkg::f_sx34(res));
        w_tri       = r_neg ? (r_dx > w_dxmin) : (r_dx < w_dxmin);
        w_num       = ttp_pkg::f_sat34(ttp_pkg::f_sx34(r_tmp2) +
                      ttp_pkg::f_sx34(ttp_pkg::f_sat34(ttp_pkg::f_sx34(res) <<< 1)));
        w_total     = ttp_pkg::f_sat34(ttp_pkg::f_sx34(r_accel_dur) +
                      ttp_pkg::f_sx34(r_coast_dur) + ttp_pkg::f_sx34(r_td));
        w_tdv       = ttp_pkg::f_sat34(ttp_pkg::f_sx34(r_t) - ttp_pkg::f_sx34(r_total_dur));
        w_coast_end = ttp_pkg::f_sx34(r_accel_dur) + ttp_pkg::f_sx34(r_coast_dur);
    end

    // Select the ALU operation for the current step
    always_comb begin
        alu_req.start = (r_state == ST_ISSUE);
        alu_req.op    = ttp_pkg::ALU_MUL;
        alu_req.a     = '0;
        alu_req.b     = '0;
        unique case (r_step)
            P_STOP: begin
                alu_req.op = ttp_pkg::ALU_STOP;
                alu_req.a  = r_origin_vel;
                alu_req.b  = w_max_dec;
            end
            P_TA, P_TA2: begin
                alu_req.op = ttp_pkg::ALU_QDIV;
                alu_req.a  = ttp_pkg::f_sat34(ttp_pkg::f_sx34(r_cruise_vel) -
                                              ttp_pkg::f_sx34(r_origin_vel));
                alu_req.b  = r_accel_rate;
            end
            P_TD, P_TD2: begin
                alu_req.op = ttp_pkg::ALU_QDIV;
                alu_req.a  = 32'sd0 - r_cruise_vel;
                alu_req.b  = r_decel_rate;
            end
            P_DXM1: begin
                alu_req.op = ttp_pkg::ALU_MULH;
                alu_req.a  = r_accel_dur;
                alu_req.b  = ttp_pkg::f_sat34(ttp_pkg::f_sx34(r_cruise_vel) +
                                              ttp_pkg::f_sx34(r_origin_vel));
            end
            P_DXM2: begin
                alu_req.op = ttp_pkg::ALU_MULH;
                alu_req.a  = r_td;
                alu_req.b  = r_cruise_vel;
            end
            P_VV: begin
                alu_req.a = r_origin_vel;
                alu_req.b = r_origin_vel;
            end
            P_T2: begin
                alu_req.a = r_decel_rate;
                alu_req.b = r_tmp1;
            end
            P_ARDR: begin
                alu_req.a = r_accel_rate;
                alu_req.b = r_decel_rate;
            end
            P_T4: begin
                alu_req.a = r_tmp1;
                alu_req.b = r_dx;
            end
            P_NUM: begin
                alu_req.op = ttp_pkg::ALU_QDIV;
                alu_req.a  = r_tmp1;
                alu_req.b  = ttp_pkg::f_sat34(ttp_pkg::f_sx34(r_decel_rate) -
                                              ttp_pkg::f_sx34(r_accel_rate));
            end
            P_SQRT: begin
                alu_req.op = ttp_pkg::ALU_SQRT;
                alu_req.a  = r_tmp1;
            end
            P_TV: begin
                alu_req.op = ttp_pkg::ALU_QDIV;
                alu_req.a  = ttp_pkg::f_sat34(ttp_pkg::f_sx34(r_dx) -
                                              ttp_pkg::f_sx34(r_dxmin));
                alu_req.b  = r_cruise_vel;
            end
            P_AEP1: begin
                alu_req.a = r_origin_vel;
                alu_req.b = r_accel_dur;
            end
            P_AEP2: begin
                alu_req.a = r_accel_dur;
                alu_req.b = r_accel_dur;
            end
            P_AEP3, E_A3: begin
                alu_req.op = ttp_pkg::ALU_MULH;
                alu_req.a  = r_accel_rate;
                alu_req.b  = r_tmp2;
            end
            E_A1: begin
                alu_req.a = r_origin_vel;
                alu_req.b = r_t;
            end
            E_A2: begin
                alu_req.a = r_t;
                alu_req.b = r_t;
            end
            E_A4: begin
                alu_req.a = r_accel_rate;
                alu_req.b = r_t;
            end
            E_C1: begin
                alu_req.a = r_cruise_vel;
                alu_req.b = ttp_pkg::f_sat34(ttp_pkg::f_sx34(r_t) -
                                             ttp_pkg::f_sx34(r_accel_dur));
            end
            E_D1: begin
                alu_req.a = w_tdv;
                alu_req.b = w_tdv;
            end
            E_D2: begin
                alu_req.op = ttp_pkg::ALU_MULH;
                alu_req.a  = r_decel_rate;
                alu_req.b  = r_tmp2;
            end
            E_D3: begin
                alu_req.a = r_decel_rate;
                alu_req.b = w_tdv;
            end
            default: begin
                alu_req.op = ttp_pkg::ALU_MUL;
            end
        endcase
    end

    ttp_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    // Sequencer, plan store and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_step          <= P_STOP;
            r_max_vel       <= LIMIT_RST;
            r_max_acc       <= LIMIT_RST;
            r_max_dec       <= LIMIT_RST;
            r_accel_rate    <= '0;
            r_decel_rate    <= '0;
            r_cruise_vel    <= '0;
            r_accel_dur     <= '0;
            r_coast_dur     <= '0;
            r_total_dur     <= '0;
            r_origin_pos    <= '0;
            r_goal_pos      <= '0;
            r_origin_vel    <= '0;
            r_accel_end_pos <= '0;
            r_dx            <= '0;
            r_dxmin         <= '0;
            r_td            <= '0;
            r_tmp1          <= '0;
            r_tmp2          <= '0;
            r_t             <= '0;
            r_neg           <= 1'b0;
            r_res_pos       <= '0;
            r_res_vel       <= '0;
            r_res_acc       <= '0;
            r_res_done      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_out_pos       <= '0;
            r_out_vel       <= '0;
            r_out_acc       <= '0;
            r_out_done      <= 1'b0;
            r_out_mt        <= '0;
        end else begin
            // Write limit registers
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MAX_VEL: r_max_vel <= i_cfg_data;
                    CFG_MAX_ACC: r_max_acc <= i_cfg_data;
                    CFG_MAX_DEC: r_max_dec <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the result once transferred, unless a new one is loaded
            if (r_out_valid && !i_out_stall && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_res_pos <= '0;
                        r_res_vel <= '0;
                        r_res_acc <= '0;
                        if (i_operation == OP_PLAN) begin
                            r_origin_pos <= i_start_position;
                            r_goal_pos   <= i_target_position;
                            r_origin_vel <= i_start_velocity;
                            r_dx         <= ttp_pkg::f_sat34(
                                                ttp_pkg::f_sx34(i_target_position) -
                                                ttp_pkg::f_sx34(i_start_position));
                            r_res_done   <= 1'b0;
                            r_step       <= P_STOP;
                            r_state      <= ST_ISSUE;
                        end else begin
                            // Pick the phase from the stored phase ends
                            r_t        <= i_eval_time;
                            r_res_done <= !(i_eval_time < r_total_dur);
                            priority if (i_eval_time[31]) begin
                                r_res_pos <= r_origin_pos;
                                r_res_vel <= r_origin_vel;
                                r_state   <= ST_OUT;
                            end else if (i_eval_time < r_accel_dur) begin
                                r_step  <= E_A1;
                                r_state <= ST_ISSUE;
                            end else if (ttp_pkg::f_sx34(i_eval_time) < w_coast_end) begin
                                r_step  <= E_C1;
                                r_state <= ST_ISSUE;
                            end else if (i_eval_time < r_total_dur) begin
                                r_step  <= E_D1;
                                r_state <= ST_ISSUE;
                            end else begin
                                r_res_pos <= r_goal_pos;
                                r_state   <= ST_OUT;
                            end
                        end
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (alu_rsp.done) begin
                        r_state <= ST_ISSUE;
                        unique case (r_step)
                            P_STOP: begin
                                r_neg        <= w_neg;
                                r_accel_rate <= w_flip ? (32'sd0 - w_ar0) : w_ar0;
                                r_decel_rate <= w_dr;
                                r_cruise_vel <= w_vr;
                                r_step       <= P_TA;
                            end
                            P_TA: begin
                                r_accel_dur <= res;
                                r_step      <= P_TD;
                            end
                            P_TD: begin
                                r_td   <= res;
                                r_step <= P_DXM1;
                            end
                            P_DXM1: begin
                                r_tmp1 <= res;
                                r_step <= P_DXM2;
                            end
                            P_DXM2: begin
                                r_dxmin <= w_dxmin;
                                r_step  <= w_tri ? P_VV : P_TV;
                            end
                            P_VV: begin
                                r_tmp1 <= res;
                                r_step <= P_T2;
                            end
                            P_T2: begin
                                r_tmp2 <= res;
                                r_step <= P_ARDR;
                            end
                            P_ARDR: begin
                                r_tmp1 <= res;
                                r_step <= P_T4;
                            end
                            P_T4: begin
                                r_tmp1 <= w_num;
                                r_step <= P_NUM;
                            end
                            P_NUM: begin
                                r_tmp1 <= res[31] ? 32'sd0 : res;
                                r_step <= P_SQRT;
                            end
                            P_SQRT: begin
                                r_cruise_vel <= r_neg ? (32'sd0 - res) : res;
                                r_step       <= P_TA2;
                            end
                            P_TA2: begin
                                r_accel_dur <= res[31] ? 32'sd0 : res;
                                r_step      <= P_TD2;
                            end
                            P_TD2: begin
                                r_td        <= res[31] ? 32'sd0 : res;
                                r_coast_dur <= '0;
                                r_step      <= P_AEP1;
                            end
                            P_TV: begin
                                r_coast_dur <= res;
                                r_step      <= P_AEP1;
                            end
                            P_AEP1: begin
                                r_tmp1      <= res;
                                r_total_dur <= w_total;
                                r_step      <= P_AEP2;
                            end
                            P_AEP2: begin
                                r_tmp2 <= res;
                                r_step <= P_AEP3;
                            end
                            P_AEP3: begin
                                r_accel_end_pos <= ttp_pkg::f_sat34(
                                    ttp_pkg::f_sx34(r_origin_pos) +
                                    ttp_pkg::f_sx34(r_tmp1) + ttp_pkg::f_sx34(res));
                                r_state <= ST_OUT;
                            end
                            E_A1: begin
                                r_tmp1 <= res;
                                r_step <= E_A2;
                            end
                            E_A2: begin
                                r_tmp2 <= res;
                                r_step <= E_A3;
                            end
                            E_A3: begin
                                r_res_pos <= ttp_pkg::f_sat34(
                                    ttp_pkg::f_sx34(r_origin_pos) +
                                    ttp_pkg::f_sx34(r_tmp1) + ttp_pkg::f_sx34(res));
                                r_step <= E_A4;
                            end
                            E_A4: begin
                                r_res_vel <= ttp_pkg::f_sat34(ttp_pkg::f_sx34(r_origin_vel) +
                                                              ttp_pkg::f_sx34(res));
                                r_res_acc <= r_accel_rate;
                                r_state   <= ST_OUT;
                            end
                            E_C1: begin
                                r_res_pos <= ttp_pkg::f_sat34(ttp_pkg::f_sx34(r_accel_end_pos) +
                                                              ttp_pkg::f_sx34(res));
                                r_res_vel <= r_cruise_vel;
                                r_state   <= ST_OUT;
                            end
                            E_D1: begin
                                r_tmp2 <= res;
                                r_step <= E_D2;
                            end
                            E_D2: begin
                                r_res_pos <= ttp_pkg::f_sat34(ttp_pkg::f_sx34(r_goal_pos) +
                                                              ttp_pkg::f_sx34(res));
                                r_step <= E_D3;
                            end
                            E_D3: begin
                                r_res_vel <= res;
                                r_res_acc <= r_decel_rate;
                                r_state   <= ST_OUT;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_OUT: begin
                    // Load the output register once it is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_pos   <= r_res_pos;
                        r_out_vel   <= r_res_vel;
                        r_out_acc   <= r_res_acc;
                        r_out_done  <= r_res_done;
                        r_out_mt    <= r_total_dur;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_position     = r_out_pos;
    assign o_velocity     = r_out_vel;
    assign o_acceleration = r_out_acc;
    assign o_done_res     = r_out_done;
    assign o_move_time    = r_out_mt;

    // The ALU answers only while the sequencer waits for it
    a_alu_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == ST_WAIT))
        else $error("ALU result arrived outside the wait state");

    // An accepted item always starts work
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state != ST_IDLE))
        else $error("accepted item did not start");

    // A finished result waits while the output register is stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_out_valid && i_out_stall) |=> (r_state == ST_OUT))
        else $error("result left the sequencer over a stalled output");

endmodule
